>>> src/csx_pkg.sv
// Package for the CAN signal extract and scale block.
// Holds the register index codes and shared types; depends on nothing.
`default_nettype none

package csx_pkg;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_START_BIT      = 3'd0;
    localparam t_cfg_idx CFG_SIGNAL_WIDTH   = 3'd1;
    localparam t_cfg_idx CFG_MOTOROLA_ORDER = 3'd2;
    localparam t_cfg_idx CFG_SIGNED_VALUE   = 3'd3;
    localparam t_cfg_idx CFG_SCALE_FACTOR   = 3'd4;
    localparam t_cfg_idx CFG_SCALE_OFFSET   = 3'd5;

    localparam int unsigned FRAME_W = 64;
    localparam int unsigned RAW_W   = 32;
    localparam int unsigned PHYS_W  = 64;

    typedef logic [5:0]         t_bitpos;
    typedef logic [RAW_W-1:0]   t_raw;
    typedef logic [PHYS_W-1:0]  t_phys;

    localparam t_bitpos RST_START_BIT    = 6'd0;
    localparam t_bitpos RST_SIGNAL_WIDTH = 6'd8;
    localparam logic signed [31:0] RST_SCALE_FACTOR = 32'sd65536;
    localparam logic signed [31:0] RST_SCALE_OFFSET = 32'sd0;

    localparam logic signed [PHYS_W-1:0] PHYS_MAX = {1'b0, {(PHYS_W-1){1'b1}}};
    localparam logic signed [PHYS_W-1:0] PHYS_MIN = {1'b1, {(PHYS_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> src/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block: four-stage pipeline.
// Depends on csx_pkg for register codes, types and saturation limits.
//
// Channel   Direction  Handshake             Payload
// command   in         start (busy is low)   i_frame_bytes[63:0]
// result    out        o_done, one cycle     o_raw_field[31:0], o_physical_value[63:0]
// config    in         i_cfg_we              i_cfg_idx[2:0], i_cfg_data[31:0]
//
// One transaction enters per cycle; each result passes the stage 1, 2 and 3 registers and the output registers.
// Stages: field shift, mask and sign extension, 33x32 multiply, offset add with saturation.
// busy is always low: the pipeline never stalls, since the receiver cannot hold results.
// Synchronous active-low reset clears the valid bits and loads the register reset values.
`default_nettype none

module can_signal_extract_scale
    import csx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_frame_bytes,
    output logic             o_done,
    output logic [31:0]      o_raw_field,
    output logic signed [63:0] o_physical_value,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_bitpos            r_start_bit;
    t_bitpos            r_signal_width;
    logic               r_motorola;
    logic               r_signed;
    logic signed [31:0] r_factor;
    logic signed [31:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bit    <= RST_START_BIT;
            r_signal_width <= RST_SIGNAL_WIDTH;
            r_motorola     <= 1'b0;
            r_signed       <= 1'b0;
            r_factor       <= RST_SCALE_FACTOR;
            r_offset       <= RST_SCALE_OFFSET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_BIT:      r_start_bit    <= i_cfg_data[5:0];
                CFG_SIGNAL_WIDTH:   r_signal_width <= i_cfg_data[5:0];
                CFG_MOTOROLA_ORDER: r_motorola     <= i_cfg_data[0];
                CFG_SIGNED_VALUE:   r_signed       <= i_cfg_data[0];
                CFG_SCALE_FACTOR:   r_factor       <= $signed(i_cfg_data);
                CFG_SCALE_OFFSET:   r_offset       <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    t_bitpos      width;
    t_bitpos      moto_msb;
    logic [6:0]   moto_shift;
    logic [63:0]  frame_swap;
    logic [95:0]  intel_word;
    logic [95:0]  moto_word;
    t_raw         n_s1_ext;

    assign width    = (r_signal_width > 6'd32) ? 6'd32 : r_signal_width;
    assign moto_msb = {r_start_bit[5:3], ~r_start_bit[2:0]};

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            frame_swap[8*b +: 8] = i_frame_bytes[8*(7-b) +: 8];
        end
        moto_shift = 7'd96 - {1'b0, moto_msb} - {1'b0, width};
        intel_word = {32'b0, i_frame_bytes} >> r_start_bit;
        moto_word  = {frame_swap, 32'b0} >> moto_shift;
        n_s1_ext   = r_motorola ? moto_word[31:0] : intel_word[31:0];
    end

    // stage 1: shifted field
    logic r_s1_vld;
    t_raw r_s1_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ext <= n_s1_ext;
    end

    t_raw       mask;
    logic [4:0] sign_pos;
    t_raw       n_s2_raw;

    always_comb begin
        sign_pos = 5'(width - 6'd1);
        if (width == 6'd0) begin
            mask = '0;
        end else begin
            mask = {RAW_W{1'b1}} >> (6'd32 - width);
        end
        n_s2_raw = r_s1_ext & mask;
        if (r_signed && width != 6'd0 && width != 6'd32 && n_s2_raw[sign_pos]) begin
            n_s2_raw = n_s2_raw | ~mask;
        end
    end

    // stage 2: masked and extended raw value
    logic r_s2_vld;
    t_raw r_s2_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_raw <= n_s2_raw;
    end

    logic signed [32:0] raw_ext;
    logic signed [64:0] product;

    assign raw_ext = r_signed ? $signed({r_s2_raw[31], r_s2_raw})
                              : $signed({1'b0, r_s2_raw});
    assign product = raw_ext * r_factor;

    // stage 3: product
    logic               r_s3_vld;
    t_raw               r_s3_raw;
    logic signed [63:0] r_s3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_raw  <= r_s2_raw;
        r_s3_prod <= product[63:0];
    end

    logic signed [65:0] sum;
    logic signed [63:0] n_phys;

    always_comb begin
        sum = {{2{r_s3_prod[63]}}, r_s3_prod} + {{34{r_offset[31]}}, r_offset};
        if (sum > $signed({{2{1'b0}}, PHYS_MAX})) begin
            n_phys = PHYS_MAX;
        end else if (sum < $signed({{2{1'b1}}, PHYS_MIN})) begin
            n_phys = PHYS_MIN;
        end else begin
            n_phys = sum[63:0];
        end
    end

    // stage 4: output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_raw_field      <= r_s3_raw;
        o_physical_value <= n_phys;
    end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for can_signal_extract_scale: directed and random frames, every result checked.
// Holds a bit-accurate decoder of the field walk and Q16.16 scaling, fed from the config writes.
// Depends on csx_pkg for register codes, result types and saturation limits.
`timescale 1ns / 1ps

module tb_top;
    import csx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned NUM_PHASES  = 20;
    localparam int unsigned PHASE_ITEMS = 62;

    typedef struct packed {
        t_raw  raw;
        t_phys phys;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_frame_bytes = '0;
    logic        o_done;
    logic [31:0] o_raw_field;
    logic signed [63:0] o_physical_value;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_START_BIT;
    logic [31:0] i_cfg_data = '0;

    logic [5:0]         cfg_start;
    logic [5:0]         cfg_width;
    logic               cfg_motorola;
    logic               cfg_signed;
    logic signed [31:0] cfg_factor;
    logic signed [31:0] cfg_offset;

    t_decoded    expected_q[$];
    t_decoded    oldest;
    int unsigned n_err = 0;
    int unsigned cycle_count = 0;

    can_signal_extract_scale dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_frame_bytes    (i_frame_bytes),
        .o_done           (o_done),
        .o_raw_field      (o_raw_field),
        .o_physical_value (o_physical_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_decoded decode_frame(input logic [63:0] frame);
        t_decoded           res;
        int unsigned        width;
        int unsigned        pos;
        logic               fbit;
        logic [31:0]        raw;
        longint             rawv;
        longint             prod;
        longint             off;
        logic signed [65:0] total;
        width = (cfg_width > 6'd32) ? 32 : int'(cfg_width);
        pos = cfg_start;
        raw = '0;
        for (int i = 0; i < width; i++) begin
            fbit = (pos > 63) ? 1'b0 : frame[pos[5:0]];
            if (cfg_motorola) begin
                raw = {raw[30:0], fbit};
                if (pos % 8 == 0) pos += 15;
                else pos -= 1;
            end else begin
                raw[i] = fbit;
                pos += 1;
            end
        end
        if (cfg_signed && width > 0 && width < 32 && raw[width-1])
            raw = raw | ~((32'd1 << width) - 32'd1);
        rawv = cfg_signed ? longint'($signed(raw)) : longint'(raw);
        prod = rawv * longint'(cfg_factor);
        off = longint'(cfg_offset);
        total = prod;
        total = total + off;
        res.raw = raw;
        if (total[65:63] != 3'b000 && total[65:63] != 3'b111)
            res.phys = total[65] ? PHYS_MIN : PHYS_MAX;
        else
            res.phys = total[63:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        n_err++;
        if (n_err <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_start    <= RST_START_BIT;
            cfg_width    <= RST_SIGNAL_WIDTH;
            cfg_motorola <= 1'b0;
            cfg_signed   <= 1'b0;
            cfg_factor   <= RST_SCALE_FACTOR;
            cfg_offset   <= RST_SCALE_OFFSET;
        end else begin
            if (start && !busy)
                expected_q.insert(expected_q.size(), decode_frame(i_frame_bytes));
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: raw %h phys %h",
                                 o_raw_field, o_physical_value);
                end else begin
                    oldest = expected_q.pop_front();
                    if (oldest.raw !== o_raw_field)
                        report_mismatch("raw_field", 64'(oldest.raw), 64'(o_raw_field));
                    if (oldest.phys !== o_physical_value)
                        report_mismatch("physical_value", oldest.phys, o_physical_value);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_BIT:      cfg_start    <= i_cfg_data[5:0];
                    CFG_SIGNAL_WIDTH:   cfg_width    <= i_cfg_data[5:0];
                    CFG_MOTOROLA_ORDER: cfg_motorola <= i_cfg_data[0];
                    CFG_SIGNED_VALUE:   cfg_signed   <= i_cfg_data[0];
                    CFG_SCALE_FACTOR:   cfg_factor   <= i_cfg_data;
                    CFG_SCALE_OFFSET:   cfg_offset   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_frame(input logic [63:0] frame);
        start <= 1'b1;
        i_frame_bytes <= frame;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Narrow registers get random junk above their width.
    task automatic load_config(input logic [5:0] sb, input logic [5:0] wd, input logic moto,
                               input logic sgn, input logic [31:0] fac,
                               input logic [31:0] off);
        wait_drained();
        write_reg(CFG_START_BIT, ($urandom() & ~32'h3F) | 32'(sb));
        write_reg(CFG_SIGNAL_WIDTH, ($urandom() & ~32'h3F) | 32'(wd));
        write_reg(CFG_MOTOROLA_ORDER, ($urandom() & ~32'h1) | 32'(moto));
        write_reg(CFG_SIGNED_VALUE, ($urandom() & ~32'h1) | 32'(sgn));
        write_reg(CFG_SCALE_FACTOR, fac);
        write_reg(CFG_SCALE_OFFSET, off);
    endtask

    task automatic test_reset_values();
        send_frame(64'h0);
        send_frame('1);
        send_frame(64'h0123_4567_89AB_CDEF);
    endtask

    task automatic test_intel_layout();
        load_config(6'd0, 6'd32, 1'b0, 1'b0, 32'h0001_0000, 32'h0);
        send_frame('1);
        send_frame(64'h5555_5555_AAAA_AAAA);
        load_config(6'd63, 6'd32, 1'b0, 1'b0, 32'h0001_0000, 32'h0);
        send_frame('1);
        load_config(6'd40, 6'd63, 1'b0, 1'b0, 32'h0000_8000, 32'hFFFF_0000);
        send_frame(64'hDEAD_BEEF_CAFE_F00D);
        load_config(6'd5, 6'd0, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h1234_5678);
        send_frame('1);
    endtask

    task automatic test_motorola_layout();
        load_config(6'd7, 6'd16, 1'b1, 1'b0, 32'h0001_0000, 32'h0);
        send_frame(64'h0000_0000_0000_A55A);
        load_config(6'd0, 6'd32, 1'b1, 1'b0, 32'h0001_0000, 32'h0);
        send_frame(64'h8877_6655_4433_2211);
        load_config(6'd63, 6'd32, 1'b1, 1'b0, 32'h0001_0000, 32'h0);
        send_frame('1);
        load_config(6'd56, 6'd8, 1'b1, 1'b0, 32'hFFFF_0000, 32'h0000_0100);
        send_frame(64'h8100_0000_0000_0000);
    endtask

    task automatic test_signed_fields();
        load_config(6'd3, 6'd1, 1'b0, 1'b1, 32'h0001_0000, 32'h0);
        send_frame('1);
        send_frame(64'h0);
        load_config(6'd31, 6'd32, 1'b1, 1'b1, 32'h0002_0000, 32'h0);
        send_frame(64'hF0F0_F0F0_8000_0080);
        load_config(6'd10, 6'd0, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000);
        send_frame('1);
        load_config(6'd12, 6'd12, 1'b1, 1'b1, 32'hFFFF_8000, 32'h0000_4000);
        send_frame(64'h3C5A_96E1_0FF0_1E2D);
    endtask

    task automatic test_scale_limits();
        load_config(6'd0, 6'd32, 1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000);
        send_frame('1);
        load_config(6'd0, 6'd32, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_frame('1);
        load_config(6'd0, 6'd32, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_frame(64'h0000_0000_8000_0000);
    endtask

    // Writes to unused indexes must leave every register alone.
    task automatic test_unknown_index();
        wait_drained();
        write_reg(t_cfg_idx'(6), $urandom());
        write_reg(t_cfg_idx'(7), $urandom());
        send_frame(64'hFEDC_BA98_7654_3210);
        send_frame(64'h7FFF_FFFF_FFFF_FFFE);
    endtask

    task automatic test_random_traffic();
        logic [5:0]  sb;
        logic [5:0]  wd;
        logic [31:0] fac;
        logic [31:0] off;
        logic [63:0] frame;
        int unsigned idle_pct;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: sb = 6'd0;
                1: sb = 6'd63;
                default: sb = 6'($urandom_range(0, 63));
            endcase
            case ($urandom_range(0, 5))
                0: wd = 6'd0;
                1: wd = 6'd1;
                2: wd = 6'd32;
                3: wd = 6'($urandom_range(33, 63));
                default: wd = 6'($urandom_range(1, 32));
            endcase
            case ($urandom_range(0, 4))
                0: fac = 32'h7FFF_FFFF;
                1: fac = 32'h8000_0000;
                2: fac = 32'h0001_0000;
                default: fac = $urandom();
            endcase
            case ($urandom_range(0, 4))
                0: off = 32'h7FFF_FFFF;
                1: off = 32'h8000_0000;
                2: off = 32'h0;
                default: off = $urandom();
            endcase
            load_config(sb, wd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fac, off);
            idle_pct = (phase >= NUM_PHASES - 3) ? 0 : $urandom_range(0, 3) * 10;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 7))
                    0: frame = '0;
                    1: frame = '1;
                    2: frame = 64'd1 << $urandom_range(0, 63);
                    3: frame = ~(64'd1 << $urandom_range(0, 63));
                    default: frame = {$urandom(), $urandom()};
                endcase
                send_frame(frame);
                if (phase == NUM_PHASES / 2 && k == PHASE_ITEMS / 2)
                    wait_drained();
                else if ($urandom_range(1, 100) <= idle_pct)
                    pause_sender($urandom_range(1, 19));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_intel_layout();
        test_motorola_layout();
        test_signed_fields();
        test_scale_limits();
        test_unknown_index();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0d results never arrived", expected_q.size());
            n_err += expected_q.size();
        end
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
